// File: hdl/icaf_pkg.sv
`default_nettype none
package icaf_pkg;

  localparam int unsigned CordicIterDefault = 20;
  localparam int unsigned CordicW = 36;
  localparam int unsigned AngW = 36;
  localparam logic signed [AngW-1:0] Deg90Q24 = 36'sd1509949440;
  localparam logic [29:0] InvGainQ30 = 30'd652032874;
  localparam logic [15:0] BlendReset = 16'd64225;
  localparam logic [23:0] ScaleReset = 24'd1311440;

  typedef enum logic [0:0] {
    CFG_BLEND = 1'b0,
    CFG_SCALE = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_ROOT_MUL,
    ST_PITCH,
    ST_ROLL,
    ST_GYRO,
    ST_BLEND_P,
    ST_BLEND_R,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
  } cordic_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

  function automatic logic signed [AngW-1:0] atan_entry(input logic [4:0] i);
    logic signed [AngW-1:0] v;
    begin
      v = '0;
      case (i)
        5'd0: v = 36'sd754974720;
        5'd1: v = 36'sd445687602;
        5'd2: v = 36'sd235489088;
        5'd3: v = 36'sd119537938;
        5'd4: v = 36'sd60000934;
        5'd5: v = 36'sd30029717;
        5'd6: v = 36'sd15018523;
        5'd7: v = 36'sd7509720;
        5'd8: v = 36'sd3754917;
        5'd9: v = 36'sd1877466;
        5'd10: v = 36'sd938734;
        5'd11: v = 36'sd469367;
        5'd12: v = 36'sd234684;
        5'd13: v = 36'sd117342;
        5'd14: v = 36'sd58671;
        5'd15: v = 36'sd29335;
        5'd16: v = 36'sd14668;
        5'd17: v = 36'sd7334;
        5'd18: v = 36'sd3667;
        5'd19: v = 36'sd1833;
        5'd20: v = 36'sd917;
        5'd21: v = 36'sd458;
        5'd22: v = 36'sd229;
        5'd23: v = 36'sd115;
        5'd24: v = 36'sd57;
        5'd25: v = 36'sd29;
        5'd26: v = 36'sd14;
        5'd27: v = 36'sd7;
        5'd28: v = 36'sd4;
        5'd29: v = 36'sd2;
        5'd30: v = 36'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

// File: hdl/icaf_if.sv
`default_nettype none
interface icaf_if #(parameter int unsigned W = 96) (input wire logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/icaf_cordic.sv
`default_nettype none
// Vectoring CORDIC: one micro-rotation per cycle; atan2 with quadrant pre-rotation.
module icaf_cordic #(
  parameter int unsigned ITER = icaf_pkg::CordicIterDefault
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire icaf_pkg::cordic_req_t                   req,
  output icaf_pkg::cordic_sts_t                        sts,
  output logic signed [icaf_pkg::CordicW-1:0]          mag,
  output logic signed [icaf_pkg::AngW-1:0]             ang
);
  localparam int unsigned CW = $clog2(ITER + 1);

  logic signed [icaf_pkg::CordicW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [icaf_pkg::AngW-1:0] z_r, z_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic signed [icaf_pkg::CordicW-1:0] dx, dy;
  logic signed [icaf_pkg::AngW-1:0] at;

  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign at = icaf_pkg::atan_entry(5'(cnt_r));

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (req.start) begin
      cnt_nxt = '0;
      z_nxt = '0;
      x_nxt = req.x;
      y_nxt = req.y;
      busy_nxt = 1'b1;
      if (req.x == '0 && req.y == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (req.x < 0) begin
        if (req.y >= 0) begin
          x_nxt = req.y; y_nxt = -req.x; z_nxt = icaf_pkg::Deg90Q24;
        end else begin
          x_nxt = -req.y; y_nxt = req.x; z_nxt = -icaf_pkg::Deg90Q24;
        end
      end
    end else if (busy_r) begin
      if (y_r >= 0) begin
        x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - at;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(ITER - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign mag = x_r;
  assign ang = z_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("cordic done while busy");
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start && cnt_r == CW'(ITER - 1)) |=> done_r)
    else $error("cordic did not finish");
  a_cnt_rng: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r < CW'(ITER))
    else $error("cordic count overrun");
endmodule
`default_nettype wire

// File: hdl/imu_complementary_attitude_filter_top.sv
`default_nettype none
// One sample at a time: three passes of the shared CORDIC and the multiply steps lie between
// an input beat and its result; input is not ready until the final step is done.
// Output register holds the result until taken; a held result stalls only the final step.
// Reset (synchronous, rst_n low): angles zero, registers to their reset values, channels idle.
module imu_complementary_attitude_filter_top #(
  parameter int unsigned CORDIC_ITERATIONS = icaf_pkg::CordicIterDefault
) (
  input  wire logic clk,
  input  wire logic rst_n,
  icaf_if.sink      in_ch,
  icaf_if.source    out_ch,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  localparam int unsigned W = icaf_pkg::CordicW;

  icaf_pkg::state_t st_r, st_nxt;
  logic [15:0] blend_r;
  logic [23:0] scale_r;
  logic signed [31:0] pitch_r, roll_r, yaw_r;
  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;
  logic signed [31:0] accp_r, accr_r;
  logic signed [33:0] dpx_r, dpy_r;
  logic [1:0] gsel_r;
  logic cstart;
  icaf_pkg::cordic_req_t req;
  icaf_pkg::cordic_sts_t sts;
  logic signed [W-1:0] cmag;
  logic signed [icaf_pkg::AngW-1:0] cang;
  logic out_valid_r;
  logic [95:0] out_data_r;
  logic out_load;

  // shared multiplier, registered
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [65:0] mp_r;
  logic signed [72:0] bsum_r;

  assign in_ch.ready = (st_r == icaf_pkg::ST_IDLE);
  assign out_load = (st_r == icaf_pkg::ST_OUT) && (!out_valid_r || out_ch.ready);

  function automatic logic signed [31:0] rnd8(input logic signed [icaf_pkg::AngW-1:0] v);
    logic signed [icaf_pkg::AngW:0] t;
    begin
      t = {v[icaf_pkg::AngW-1], v} + 37'sd128;
      return 32'(t >>> 8);
    end
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [72:0] v);
    begin
      if (v > 73'sd2147483647) return 32'sh7fffffff;
      if (v < -73'sd2147483648) return 32'sh80000000;
      return v[31:0];
    end
  endfunction

  always_comb begin
    ma = '0; mb = '0;
    case (st_r)
      icaf_pkg::ST_ROOT_MUL: begin
        ma = 33'(cmag); mb = 33'($signed({1'b0, icaf_pkg::InvGainQ30}));
      end
      icaf_pkg::ST_GYRO: begin
        mb = 33'($signed({1'b0, scale_r}));
        case (gsel_r)
          2'd0: ma = 33'(gx_r);
          2'd1: ma = 33'(gy_r);
          default: ma = 33'(gz_r);
        endcase
      end
      icaf_pkg::ST_BLEND_P: begin
        ma = 33'($signed({1'b0, blend_r}));
        mb = 33'(32'(pitch_r) + dpy_r);
        if (gsel_r == 2'd1) begin
          ma = 33'(18'sd65536 - $signed({1'b0, blend_r})); mb = 33'(accp_r);
        end
      end
      icaf_pkg::ST_BLEND_R: begin
        ma = 33'($signed({1'b0, blend_r}));
        mb = 33'(roll_r - dpx_r);
        if (gsel_r == 2'd1) begin
          ma = 33'(18'sd65536 - $signed({1'b0, blend_r})); mb = 33'(accr_r);
        end
      end
      default: begin
        ma = '0; mb = '0;
      end
    endcase
    mp = ma * mb;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      icaf_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready) st_nxt = icaf_pkg::ST_ROOT;
      icaf_pkg::ST_ROOT: if (sts.done) st_nxt = icaf_pkg::ST_ROOT_MUL;
      icaf_pkg::ST_ROOT_MUL: if (gsel_r == 2'd1) st_nxt = icaf_pkg::ST_PITCH;
      icaf_pkg::ST_PITCH: if (sts.done) st_nxt = icaf_pkg::ST_ROLL;
      icaf_pkg::ST_ROLL: if (sts.done) st_nxt = icaf_pkg::ST_GYRO;
      icaf_pkg::ST_GYRO: if (gsel_r == 2'd3) st_nxt = icaf_pkg::ST_BLEND_P;
      icaf_pkg::ST_BLEND_P: if (gsel_r == 2'd2) st_nxt = icaf_pkg::ST_BLEND_R;
      icaf_pkg::ST_BLEND_R: if (gsel_r == 2'd2) st_nxt = icaf_pkg::ST_OUT;
      icaf_pkg::ST_OUT: if (!out_valid_r || out_ch.ready) st_nxt = icaf_pkg::ST_IDLE;
      default: st_nxt = icaf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cstart = 1'b0;
    req.x = '0; req.y = '0;
    case (st_r)
      icaf_pkg::ST_IDLE: begin
        cstart = in_ch.valid && in_ch.ready;
        req.x = $signed(in_ch.data[47:32]) < 0 ? -(W'($signed(in_ch.data[47:32])) <<< 14)
                                               : (W'($signed(in_ch.data[47:32])) <<< 14);
        req.y = $signed(in_ch.data[31:16]) < 0 ? -(W'($signed(in_ch.data[31:16])) <<< 14)
                                               : (W'($signed(in_ch.data[31:16])) <<< 14);
      end
      icaf_pkg::ST_ROOT_MUL: begin
        cstart = (gsel_r == 2'd1);
        req.x = W'((mp_r + 66'sd536870912) >>> 30);
        req.y = -(W'(ax_r) <<< 14);
      end
      icaf_pkg::ST_PITCH: begin
        cstart = sts.done;
        req.x = W'(az_r) <<< 14;
        req.y = -(W'(ay_r) <<< 14);
      end
      default: begin
        cstart = 1'b0;
      end
    endcase
    req.start = cstart;
  end

  always_ff @(posedge clk) begin
    mp_r <= mp;
    if (in_ch.valid && in_ch.ready) begin
      ax_r <= in_ch.data[15:0]; ay_r <= in_ch.data[31:16]; az_r <= in_ch.data[47:32];
      gx_r <= in_ch.data[63:48]; gy_r <= in_ch.data[79:64]; gz_r <= in_ch.data[95:80];
    end
    if (st_r == icaf_pkg::ST_PITCH && sts.done) accp_r <= rnd8(cang);
    if (st_r == icaf_pkg::ST_ROLL && sts.done) accr_r <= rnd8(cang);
    if (out_load) out_data_r <= {yaw_r, roll_r, pitch_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= icaf_pkg::ST_IDLE;
      gsel_r <= '0;
      blend_r <= icaf_pkg::BlendReset;
      scale_r <= icaf_pkg::ScaleReset;
      pitch_r <= '0; roll_r <= '0; yaw_r <= '0;
      out_valid_r <= 1'b0;
      bsum_r <= '0;
      dpx_r <= '0; dpy_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          icaf_pkg::CFG_BLEND: blend_r <= cfg_data[15:0];
          icaf_pkg::CFG_SCALE: scale_r <= cfg_data;
          default: ;
        endcase
      end
      gsel_r <= (st_nxt != st_r) ? 2'd0 : gsel_r + 2'd1;
      if (st_r == icaf_pkg::ST_GYRO && gsel_r != 2'd0) begin
        case (gsel_r)
          2'd1: dpx_r <= 34'((mp_r + 66'sd32768) >>> 16);
          2'd2: dpy_r <= 34'((mp_r + 66'sd32768) >>> 16);
          default: yaw_r <= sat(73'(yaw_r) + 73'((mp_r + 66'sd32768) >>> 16));
        endcase
      end
      if (st_r == icaf_pkg::ST_BLEND_P || st_r == icaf_pkg::ST_BLEND_R) begin
        if (gsel_r == 2'd1) bsum_r <= 73'(mp_r);
        if (gsel_r == 2'd2) begin
          if (st_r == icaf_pkg::ST_BLEND_P)
            pitch_r <= sat((bsum_r + 73'(mp_r) + 73'sd32768) >>> 16);
          else
            roll_r <= sat((bsum_r + 73'(mp_r) + 73'sd32768) >>> 16);
        end
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_data_r;

  icaf_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .req(req), .sts(sts), .mag(cmag), .ang(cang)
  );

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_data_r)) else $error("result changed");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r) else $error("result dropped");
  a_idle_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == icaf_pkg::ST_IDLE) |-> !sts.busy) else $error("cordic busy in idle");
endmodule
`default_nettype wire

// File: test/icaf_checker.sv
module icaf_checker #(
  parameter int unsigned ITERS = icaf_pkg::CordicIterDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [95:0] in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [95:0] out_data,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          fails,
  output int          pending,
  output int          beats_seen
);
  typedef struct packed {
    logic signed [31:0] yaw;
    logic signed [31:0] roll;
    logic signed [31:0] pitch;
  } attitude_t;

  attitude_t   attitude_q[$];
  logic [15:0] weight;
  logic [23:0] step_scale;
  longint      pitch_st, roll_st, yaw_st;

  localparam longint Deg90 = 64'sd1509949440;
  localparam longint InvGain = 64'sd652032874;

  function automatic longint atan_deg(input int i);
    longint t[32] = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
                      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
                      117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
                      115, 57, 29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rotate_vec(inout longint x, input longint y, input longint z);
    longint dx, dy;
    for (int i = 0; i < ITERS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_deg(i);
      end else begin
        x -= dx; y += dy; z -= atan_deg(i);
      end
    end
    return z;
  endfunction

  function automatic longint angle_of(input longint y, input longint x);
    longint z, t;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = Deg90;
      end else begin
        x = -y; y = t; z = -Deg90;
      end
    end
    return rotate_vec(x, y, z);
  endfunction

  function automatic longint magnitude(input longint a, input longint b);
    longint x, y;
    x = a < 0 ? -a : a;
    y = b < 0 ? -b : b;
    void'(rotate_vec(x, y, 0));
    return rnd_shift(x * InvGain, 30);
  endfunction

  function automatic longint mix(input longint gyro_path, input longint accel_ang);
    longint w;
    w = longint'(weight);
    return rnd_shift(w * gyro_path + (65536 - w) * accel_ang, 16);
  endfunction

  function automatic attitude_t next_attitude(input logic [95:0] d);
    longint ax, ay, az, gx, gy, gz, s, root, ap, ar;
    attitude_t r;
    ax = longint'($signed(d[15:0])) * 16384;
    ay = longint'($signed(d[31:16])) * 16384;
    az = longint'($signed(d[47:32])) * 16384;
    gx = longint'($signed(d[63:48]));
    gy = longint'($signed(d[79:64]));
    gz = longint'($signed(d[95:80]));
    s = longint'(step_scale);
    root = magnitude(az, ay);
    ap = rnd_shift(angle_of(-ax, root), 8);
    ar = rnd_shift(angle_of(-ay, az), 8);
    pitch_st = clamp32(mix(pitch_st + rnd_shift(gy * s, 16), ap));
    roll_st = clamp32(mix(roll_st - rnd_shift(gx * s, 16), ar));
    yaw_st = clamp32(yaw_st + rnd_shift(gz * s, 16));
    r.pitch = pitch_st[31:0];
    r.roll = roll_st[31:0];
    r.yaw = yaw_st[31:0];
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, $signed(got),
             $signed(want), $realtime);
    fails++;
  endtask

  initial begin
    fails = 0;
    beats_seen = 0;
  end

  assign pending = attitude_q.size();

  always @(posedge clk) begin
    attitude_t want, got;
    if (!rst_n) begin
      weight <= icaf_pkg::BlendReset;
      step_scale <= icaf_pkg::ScaleReset;
      pitch_st = 0;
      roll_st = 0;
      yaw_st = 0;
      attitude_q.delete();
    end else begin
      if (cfg_we) begin
        case (icaf_pkg::cfg_idx_t'(cfg_index))
          icaf_pkg::CFG_BLEND: weight <= cfg_data[15:0];
          icaf_pkg::CFG_SCALE: step_scale <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) attitude_q.push_back(next_attitude(in_data));
      if (out_valid && out_ready) begin
        beats_seen++;
        got = out_data;
        if (attitude_q.size() == 0) begin
          report("result beat with no sample", got.pitch, '0);
        end else begin
          want = attitude_q.pop_front();
          if (got.pitch !== want.pitch) report("pitch", got.pitch, want.pitch);
          if (got.roll !== want.roll) report("roll", got.roll, want.roll);
          if (got.yaw !== want.yaw) report("yaw", got.yaw, want.yaw);
        end
      end
    end
  end
endmodule

// File: test/tb.sv
module tb;
  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [23:0] cfg_data;
  int          fails, pending, beats_seen;
  int          in_idle, out_idle;

  icaf_if #(96) in_ch (clk);
  icaf_if #(96) out_ch (clk);

  imu_complementary_attitude_filter_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  icaf_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .beats_seen(beats_seen)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle);
    end
  end

  function automatic logic [15:0] axis_val();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [15:0] ax, ay, az, gx, gy, gz);
    while ($urandom_range(99) < in_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {gz, gy, gx, az, ay, ax};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input icaf_pkg::cfg_idx_t idx, input logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  logic [15:0] wsets[5] = '{16'd64225, 16'd0, 16'd65535, 16'd32768, 16'd1};
  logic [23:0] ssets[5] = '{24'd1311440, 24'hffffff, 24'd0, 24'd77777, 24'hffffff};

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    in_idle = 11;
    out_idle = 49;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero vector, axis extremes, roll near 180, negative-x pre-rotation
    send_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0);
    send_sample(16'h0, 16'h0, 16'hffff, 16'h0, 16'h0, 16'h0);
    send_sample(16'h0, 16'h0001, 16'h8000, 16'h0, 16'h0, 16'h0);
    send_sample(16'h0, 16'hffff, 16'h8000, 16'h0, 16'h0, 16'h0);
    send_sample(16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_sample(16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    send_sample(16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0);
    send_sample(16'h0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0);
    send_sample(16'h0, 16'h0, 16'h4000, 16'h7fff, 16'h8000, 16'h7fff);
    send_sample(16'h1234, 16'hedcb, 16'h4000, 16'h8000, 16'h7fff, 16'h8000);
    send_sample(16'hffff, 16'h0001, 16'h0001, 16'h5555, 16'haaaa, 16'h0001);

    for (int p = 0; p < 5; p++) begin
      drain();
      if (p >= 2) begin
        in_idle = (p == 4) ? 0 : 49;
        out_idle = (p == 4) ? 0 : 11;
      end
      write_reg(icaf_pkg::CFG_BLEND, {8'd0, wsets[p]});
      write_reg(icaf_pkg::CFG_SCALE, ssets[p]);
      for (int n = 0; n < 227; n++) begin
        if (p == 1 && n < 40)
          send_sample(axis_val(), axis_val(), axis_val(), 16'h7fff, 16'h7fff, 16'h7fff);
        else if (p == 4 && n < 40)
          send_sample(axis_val(), axis_val(), axis_val(), 16'h8000, 16'h8000, 16'h8000);
        else
          send_sample(axis_val(), axis_val(), axis_val(), axis_val(), axis_val(),
                      axis_val());
      end
    end
    drain();

    $display("covered %0d result beats over 5 register settings incl. zero and full-scale",
             beats_seen);
    $display("weight and step scale, with saturating and +-180 degree samples");
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end
endmodule

// File: sim.f
hdl/icaf_pkg.sv
hdl/icaf_if.sv
hdl/icaf_cordic.sv
hdl/imu_complementary_attitude_filter_top.sv
test/icaf_checker.sv
test/tb.sv
